// ----- hdl/ppid_pkg.sv -----
package ppid_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int GAIN_FRAC_BITS   = 8;

  localparam int GAIN_W    = 16;
  localparam int SEP_W     = 15;
  localparam int CLAMP_W   = 23;
  localparam int INTEG_W   = 24;
  localparam int DRIVE_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [SEP_W-1:0]   SEP_RESET   = SEP_W'(32767);
  localparam logic [CLAMP_W-1:0] CLAMP_RESET = CLAMP_W'(5000);

  localparam longint DRIVE_MAX = 64'sd2147483647;
  localparam longint DRIVE_MIN = -64'sd2147483648;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP    = 3'd0,
    REG_KI    = 3'd1,
    REG_KD    = 3'd2,
    REG_SEP   = 3'd3,
    REG_CLAMP = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
    logic [SEP_W-1:0]         sep_limit;
    logic [CLAMP_W-1:0]       integ_clamp;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic integrating;
  } stage_ctl_t;

endpackage

// ----- hdl/ppid_cfg_if.sv -----
interface ppid_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ppid_pkg::CFG_IDX_W-1:0]  idx;
  logic [ppid_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

// ----- hdl/ppid_in_if.sv -----
interface ppid_in_if #(
  parameter int SAMPLE_WIDTH = ppid_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] target;
  logic signed [SAMPLE_WIDTH-1:0] measure;

  modport source (output valid, target, measure, input ready);
  modport sink   (input valid, target, measure, output ready);
endinterface

// ----- hdl/ppid_out_if.sv -----
interface ppid_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ppid_pkg::DRIVE_W-1:0] drive;
  logic                                integrating;

  modport source (output valid, drive, integrating, input ready);
  modport sink   (input valid, drive, integrating, output ready);
endinterface

// ----- hdl/ppid_cfg_regs.sv -----
module ppid_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  ppid_cfg_if.sink        cfg_if,
  output ppid_pkg::cfg_t  cfg
);

  ppid_pkg::cfg_t cfg_r;
  ppid_pkg::cfg_t cfg_nxt;

  assign cfg_if.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_if.valid) begin
      case (ppid_pkg::cfg_idx_t'(cfg_if.idx))
        ppid_pkg::REG_KP:    cfg_nxt.kp = cfg_if.data[ppid_pkg::GAIN_W-1:0];
        ppid_pkg::REG_KI:    cfg_nxt.ki = cfg_if.data[ppid_pkg::GAIN_W-1:0];
        ppid_pkg::REG_KD:    cfg_nxt.kd = cfg_if.data[ppid_pkg::GAIN_W-1:0];
        ppid_pkg::REG_SEP:   cfg_nxt.sep_limit = cfg_if.data[ppid_pkg::SEP_W-1:0];
        ppid_pkg::REG_CLAMP: cfg_nxt.integ_clamp = cfg_if.data[ppid_pkg::CLAMP_W-1:0];
        default: ;  // unknown index, ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp          <= '0;
      cfg_r.ki          <= '0;
      cfg_r.kd          <= '0;
      cfg_r.sep_limit   <= ppid_pkg::SEP_RESET;
      cfg_r.integ_clamp <= ppid_pkg::CLAMP_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- hdl/ppid_front.sv -----
module ppid_front #(
  parameter int SAMPLE_WIDTH = ppid_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  ppid_in_if.sink                                        in_if,
  input  ppid_pkg::cfg_t                                 cfg,
  input  logic                                           prod_ready,
  output ppid_pkg::stage_ctl_t                           prod_ctl,
  output logic signed [SAMPLE_WIDTH+ppid_pkg::GAIN_W:0]  prod_kp,
  output logic signed [ppid_pkg::INTEG_W+ppid_pkg::GAIN_W-1:0] prod_ki,
  output logic signed [SAMPLE_WIDTH+ppid_pkg::GAIN_W+1:0] prod_kd
);

  localparam int W     = SAMPLE_WIDTH;
  localparam int ERR_W = W + 1;
  localparam int DER_W = W + 2;
  localparam int IW    = ((ERR_W > ppid_pkg::INTEG_W) ? ERR_W : ppid_pkg::INTEG_W) + 1;
  localparam int CW    = ((W > ppid_pkg::SEP_W + 1) ? W : ppid_pkg::SEP_W + 1) + 1;
  localparam int KP_W  = W + ppid_pkg::GAIN_W + 1;
  localparam int KI_W  = ppid_pkg::INTEG_W + ppid_pkg::GAIN_W;
  localparam int KD_W  = W + ppid_pkg::GAIN_W + 2;

  // input register
  logic                in_valid_r;
  logic signed [W-1:0] target_r;
  logic signed [W-1:0] measure_r;

  // controller state
  logic signed [ERR_W-1:0]            prev_err_r;
  logic signed [ppid_pkg::INTEG_W-1:0] integ_r;
  logic                               integ_en_r;
  logic signed [ppid_pkg::INTEG_W-1:0] integ_nxt;

  // product register
  ppid_pkg::stage_ctl_t   ctl_r;
  logic signed [KP_W-1:0] pkp_r;
  logic signed [KI_W-1:0] pki_r;
  logic signed [KD_W-1:0] pkd_r;

  logic                    fire;
  logic signed [ERR_W-1:0] error;
  logic signed [DER_W-1:0] deriv;
  logic signed [CW-1:0]    meas_x;
  logic signed [CW-1:0]    lim_x;
  logic                    inside_lim;
  logic signed [IW-1:0]    sum_x;
  logic signed [IW-1:0]    clamp_x;
  logic signed [KP_W-1:0]  pkp_nxt;
  logic signed [KI_W-1:0]  pki_nxt;
  logic signed [KD_W-1:0]  pkd_nxt;

  assign fire        = in_valid_r && (!ctl_r.valid || prod_ready);
  assign in_if.ready = !in_valid_r || fire;

  assign error = ERR_W'(target_r) - ERR_W'(measure_r);
  assign deriv = DER_W'(error) - DER_W'(prev_err_r);

  assign meas_x     = CW'(measure_r);
  assign lim_x      = CW'(signed'({1'b0, cfg.sep_limit}));
  assign inside_lim = (meas_x <= lim_x) && (meas_x >= -lim_x);

  assign sum_x   = IW'(integ_r) + IW'(error);
  assign clamp_x = IW'(signed'({1'b0, cfg.integ_clamp}));

  always_comb begin
    if (sum_x > clamp_x) begin
      integ_nxt = ppid_pkg::INTEG_W'(clamp_x);
    end else if (sum_x < -clamp_x) begin
      integ_nxt = ppid_pkg::INTEG_W'(-clamp_x);
    end else begin
      integ_nxt = ppid_pkg::INTEG_W'(sum_x);
    end
  end

  assign pkp_nxt = KP_W'(cfg.kp) * KP_W'(error);
  assign pkd_nxt = KD_W'(cfg.kd) * KD_W'(deriv);
  assign pki_nxt = integ_en_r ? (KI_W'(cfg.ki) * KI_W'(integ_r)) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      target_r  <= in_if.target;
      measure_r <= in_if.measure;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
      integ_r    <= '0;
      integ_en_r <= 1'b0;
    end else if (fire) begin
      prev_err_r <= error;
      integ_en_r <= inside_lim;
      if (inside_lim) begin
        integ_r <= integ_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (!ctl_r.valid || prod_ready) begin
      ctl_r.valid       <= fire;
      ctl_r.integrating <= integ_en_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pkp_r <= pkp_nxt;
      pki_r <= pki_nxt;
      pkd_r <= pkd_nxt;
    end
  end

  assign prod_ctl = ctl_r;
  assign prod_kp  = pkp_r;
  assign prod_ki  = pki_r;
  assign prod_kd  = pkd_r;

`ifndef SYNTHESIS
  a_outside_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !inside_lim) |=> (!integ_en_r && $stable(integ_r)))
    else $error("integral moved while measurement was outside the limit");

  a_prev_err: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> (prev_err_r == $past(error)))
    else $error("previous error not updated by item");

  a_flag_to_stage: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> (ctl_r.valid && ctl_r.integrating == $past(integ_en_r)))
    else $error("integrating flag lost on the way to the product stage");
`endif

endmodule

// ----- hdl/ppid_back.sv -----
module ppid_back #(
  parameter int SAMPLE_WIDTH = ppid_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  ppid_pkg::stage_ctl_t                           prod_ctl,
  input  logic signed [SAMPLE_WIDTH+ppid_pkg::GAIN_W:0]  prod_kp,
  input  logic signed [ppid_pkg::INTEG_W+ppid_pkg::GAIN_W-1:0] prod_ki,
  input  logic signed [SAMPLE_WIDTH+ppid_pkg::GAIN_W+1:0] prod_kd,
  output logic                                           prod_ready,
  ppid_out_if.source                                     out_if
);

  localparam int KP_W   = SAMPLE_WIDTH + ppid_pkg::GAIN_W + 1;
  localparam int KI_W   = ppid_pkg::INTEG_W + ppid_pkg::GAIN_W;
  localparam int KD_W   = SAMPLE_WIDTH + ppid_pkg::GAIN_W + 2;
  localparam int PMAX_W = (KD_W > KI_W) ? KD_W : KI_W;
  localparam int SUM_W  = PMAX_W + 2;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(ppid_pkg::DRIVE_MAX);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(ppid_pkg::DRIVE_MIN);

  logic                                out_valid_r;
  logic signed [ppid_pkg::DRIVE_W-1:0] drive_r;
  logic                                integ_r;

  logic signed [SUM_W-1:0]             acc;
  logic signed [SUM_W-1:0]             acc_sh;
  logic signed [ppid_pkg::DRIVE_W-1:0] drive_nxt;
  logic                                take;

  assign acc    = SUM_W'(prod_kp) + SUM_W'(prod_ki) + SUM_W'(prod_kd);
  assign acc_sh = acc >>> ppid_pkg::GAIN_FRAC_BITS;

  always_comb begin
    if (acc_sh > SAT_HI) begin
      drive_nxt = ppid_pkg::DRIVE_W'(SAT_HI);
    end else if (acc_sh < SAT_LO) begin
      drive_nxt = ppid_pkg::DRIVE_W'(SAT_LO);
    end else begin
      drive_nxt = acc_sh[ppid_pkg::DRIVE_W-1:0];
    end
  end

  assign prod_ready = !out_valid_r || out_if.ready;
  assign take       = prod_ctl.valid && prod_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (prod_ready) begin
      out_valid_r <= prod_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      drive_r <= drive_nxt;
      integ_r <= prod_ctl.integrating;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.drive       = drive_r;
  assign out_if.integrating = integ_r;

`ifndef SYNTHESIS
  a_item_lands: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> (out_valid_r && integ_r == $past(prod_ctl.integrating)))
    else $error("product stage item did not reach the output register");
`endif

endmodule

// ----- hdl/positional_pid_integral_separation.sv -----
// positional pid with integral separation. each input item (target, measure)
// yields exactly one result item (drive, integrating). error = target - measure,
// derivative = error - previous error, and drive = (kp*error + ki*integral +
// kd*derivative) >>> 8, floored and saturated to signed 32 bits; the ki term
// only counts when the previous item left integration enabled, and uses the
// integral from before this item. after that, a measure within
// +/-separation_limit (inclusive) enables integration, adds the error to the
// integral and clamps it to +/-integral_clamp; a measure outside disables it
// and holds the integral. gains are signed q8.8. one item per clock is
// sustained while the output is ready; each item passes through the three
// register stages: input register, gain multiplier register and output
// register. configuration registers (kp, ki, kd, separation_limit,
// integral_clamp at index 0..4) are written through the cfg channel, which is
// always ready; unknown indexes are dropped. write them only while idle.
module positional_pid_integral_separation #(
  parameter int SAMPLE_WIDTH = ppid_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ppid_cfg_if.sink   cfg_if,
  ppid_in_if.sink    in_if,
  ppid_out_if.source out_if
);

  localparam int KP_W = SAMPLE_WIDTH + ppid_pkg::GAIN_W + 1;
  localparam int KI_W = ppid_pkg::INTEG_W + ppid_pkg::GAIN_W;
  localparam int KD_W = SAMPLE_WIDTH + ppid_pkg::GAIN_W + 2;

  // live gains and limits
  ppid_pkg::cfg_t cfg;

  // handoff between the multiplier stage and the output stage
  ppid_pkg::stage_ctl_t   prod_ctl;
  logic                   prod_ready;
  logic signed [KP_W-1:0] prod_kp;
  logic signed [KI_W-1:0] prod_ki;
  logic signed [KD_W-1:0] prod_kd;

  ppid_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  // error, derivative, separation check, integral update and the three gains
  ppid_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .cfg        (cfg),
    .prod_ready (prod_ready),
    .prod_ctl   (prod_ctl),
    .prod_kp    (prod_kp),
    .prod_ki    (prod_ki),
    .prod_kd    (prod_kd)
  );

  // sum of products, fractional shift, saturation, output register
  ppid_back #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .prod_ctl   (prod_ctl),
    .prod_kp    (prod_kp),
    .prod_ki    (prod_ki),
    .prod_kd    (prod_kd),
    .prod_ready (prod_ready),
    .out_if     (out_if)
  );

endmodule

// ----- bench/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW             = ppid_pkg::SAMPLE_WIDTH_DEF;
  localparam int RANDOM_ITEMS   = 750;
  localparam int PHASES         = 6;
  localparam int ITEMS_PER_PHASE = RANDOM_ITEMS / PHASES;
  localparam int HOLD_CYCLES    = 80;     // long receiver hold-off
  localparam int HANG_LIMIT     = 2000;   // cycles without any handshake
  localparam int SETTLE_CYCLES  = 4;      // pipeline depth plus margin
  localparam int PRINT_LIMIT    = 30;

  // indexes past the last register, the block must drop these writes
  localparam logic [ppid_pkg::CFG_IDX_W-1:0] IDX_SPARE_FIRST =
    ppid_pkg::CFG_IDX_W'(ppid_pkg::REG_CLAMP + 1);
  localparam logic [ppid_pkg::CFG_IDX_W-1:0] IDX_SPARE_LAST  = '1;

  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;
  localparam logic signed [SW-1:0] HI_SAMPLE = SW'(SAMPLE_MAX);
  localparam logic signed [SW-1:0] LO_SAMPLE = SW'(SAMPLE_MIN);

  typedef struct {
    logic signed [ppid_pkg::DRIVE_W-1:0] drive;
    logic                                integrating;
  } drive_item_t;

  // tracks the controller state and holds the drive values still owed
  class pid_scoreboard_t;
    logic signed [ppid_pkg::GAIN_W-1:0]  kp, ki, kd;
    logic [ppid_pkg::SEP_W-1:0]          sep_limit;
    logic [ppid_pkg::CLAMP_W-1:0]        clamp;
    logic signed [SW:0]                  prev_err;
    logic signed [ppid_pkg::INTEG_W-1:0] integ;
    bit                                  integ_on;
    drive_item_t                         owed_drives[$];
    int errors, samples, results, integ_steps, clamp_hits, spare_writes, printed;

    function new();
      kp        = '0;
      ki        = '0;
      kd        = '0;
      sep_limit = ppid_pkg::SEP_RESET;
      clamp     = ppid_pkg::CLAMP_RESET;
      prev_err  = '0;
      integ     = '0;
      integ_on  = 1'b0;
    endfunction

    function void write_reg(logic [ppid_pkg::CFG_IDX_W-1:0]  idx,
                            logic [ppid_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        ppid_pkg::REG_KP:    kp = data[ppid_pkg::GAIN_W-1:0];
        ppid_pkg::REG_KI:    ki = data[ppid_pkg::GAIN_W-1:0];
        ppid_pkg::REG_KD:    kd = data[ppid_pkg::GAIN_W-1:0];
        ppid_pkg::REG_SEP:   sep_limit = data[ppid_pkg::SEP_W-1:0];
        ppid_pkg::REG_CLAMP: clamp = data[ppid_pkg::CLAMP_W-1:0];
        default:             spare_writes++;
      endcase
    endfunction

    function void note_sample(logic signed [SW-1:0] target, logic signed [SW-1:0] measure);
      longint err, deriv, acc, sum, lim, bound;
      drive_item_t item;
      err   = longint'(target) - longint'(measure);
      deriv = err - longint'(prev_err);
      acc   = longint'(kp) * err + longint'(kd) * deriv;
      item.integrating = integ_on;
      // integral term uses the flag and sum left by the previous item
      if (integ_on) begin
        acc += longint'(ki) * longint'(integ);
        integ_steps++;
      end
      acc = acc >>> ppid_pkg::GAIN_FRAC_BITS;
      if (acc > ppid_pkg::DRIVE_MAX) acc = ppid_pkg::DRIVE_MAX;
      if (acc < ppid_pkg::DRIVE_MIN) acc = ppid_pkg::DRIVE_MIN;
      item.drive = acc[ppid_pkg::DRIVE_W-1:0];
      // separation check, limit itself counts as inside
      lim   = longint'(sep_limit);
      bound = longint'(clamp);
      if (longint'(measure) > lim || longint'(measure) < -lim) begin
        integ_on = 1'b0;
      end else begin
        integ_on = 1'b1;
        sum = longint'(integ) + err;
        if (sum > bound) begin
          sum = bound;
          clamp_hits++;
        end
        if (sum < -bound) begin
          sum = -bound;
          clamp_hits++;
        end
        integ = sum[ppid_pkg::INTEG_W-1:0];
      end
      prev_err = err[SW:0];
      owed_drives.push_back(item);
      samples++;
    endfunction

    function void check_drive(logic signed [ppid_pkg::DRIVE_W-1:0] drive, logic integrating);
      drive_item_t want;
      results++;
      if (owed_drives.size() == 0) begin
        errors++;
        if (printed++ < PRINT_LIMIT)
          $display("%0t: result with no item waiting, drive %0d integrating %0b",
                   $time, drive, integrating);
        return;
      end
      want = owed_drives.pop_front();
      if (drive !== want.drive) begin
        errors++;
        if (printed++ < PRINT_LIMIT)
          $display("%0t: drive mismatch, expected %0d, actual %0d",
                   $time, want.drive, drive);
      end
      if (integrating !== want.integrating) begin
        errors++;
        if (printed++ < PRINT_LIMIT)
          $display("%0t: integrating mismatch, expected %0b, actual %0b",
                   $time, want.integrating, integrating);
      end
    endfunction

    function int pending();
      return owed_drives.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  ppid_cfg_if                        cfg_ch ();
  ppid_in_if #(.SAMPLE_WIDTH(SW))    in_ch ();
  ppid_out_if                        out_ch ();

  positional_pid_integral_separation #(.SAMPLE_WIDTH(SW)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_ch.sink),
    .in_if  (in_ch.sink),
    .out_if (out_ch.source)
  );

  pid_scoreboard_t sb = new();

  int cur_sep = SAMPLE_MAX;   // separation limit in force, steers the measure picks
  int settings;               // number of register settings run through
  int hold_asked;             // hold-off requests from the sender side
  int hold_served;            // hold-off requests the receiver has carried out
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // handshake monitor: results are checked before the new item is noted,
  // since a result never belongs to the item accepted at the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_ch.idx, cfg_ch.data);
      if (out_ch.valid && out_ch.ready) sb.check_drive(out_ch.drive, out_ch.integrating);
      if (in_ch.valid && in_ch.ready) sb.note_sample(in_ch.target, in_ch.measure);
    end
  end

  // watchdog on cycles in which no channel moves anything
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("%0t: watchdog, no handshake for %0d cycles, %0d results owed",
               $time, HANG_LIMIT, sb.pending());
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: stall pattern picked in stretches, plus long hold-offs on request
  initial begin
    int mode;
    int span;
    int k;
    out_ch.ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      for (k = 0; k < span; k++) begin
        @(posedge clk);
        if (hold_served != hold_asked) begin
          // hold off long enough that the pipeline fills and stalls its input
          hold_served = hold_asked;
          out_ch.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          0:       out_ch.ready <= 1'b1;                          // no stalls
          1:       out_ch.ready <= 1'($urandom_range(0, 1));      // coin flip
          2:       out_ch.ready <= (k % 4 == 0);                  // one in four
          default: out_ch.ready <= ($urandom_range(0, 4) != 0);   // mostly ready
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  // offer one item and hold it until the block takes it
  task automatic send_item(input logic signed [SW-1:0] t, input logic signed [SW-1:0] m);
    in_ch.valid   <= 1'b1;
    in_ch.target  <= t;
    in_ch.measure <= m;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // gap between bursts, no assignment at all for a zero gap so that valid
  // stays high straight into the next item
  task automatic pause_input(input int n);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // stop sending and wait for every owed result; the extra edge first lets
  // the monitor note the last accepted item
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // back-to-back writes keep valid high, end_writes drops it
  task automatic write_reg(input logic [ppid_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [ppid_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx   <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic end_writes();
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // all five registers with junk above each field, then a write to an
  // unused index that must leave everything alone
  task automatic set_config(input logic [ppid_pkg::GAIN_W-1:0]  g_p,
                            input logic [ppid_pkg::GAIN_W-1:0]  g_i,
                            input logic [ppid_pkg::GAIN_W-1:0]  g_d,
                            input logic [ppid_pkg::SEP_W-1:0]   sep,
                            input logic [ppid_pkg::CLAMP_W-1:0] clamp);
    logic [ppid_pkg::CFG_DATA_W-1:0] d;
    logic [ppid_pkg::CFG_IDX_W-1:0]  spare;
    d = $urandom(); d[ppid_pkg::GAIN_W-1:0]  = g_p;   write_reg(ppid_pkg::REG_KP, d);
    d = $urandom(); d[ppid_pkg::GAIN_W-1:0]  = g_i;   write_reg(ppid_pkg::REG_KI, d);
    d = $urandom(); d[ppid_pkg::GAIN_W-1:0]  = g_d;   write_reg(ppid_pkg::REG_KD, d);
    d = $urandom(); d[ppid_pkg::SEP_W-1:0]   = sep;   write_reg(ppid_pkg::REG_SEP, d);
    d = $urandom(); d[ppid_pkg::CLAMP_W-1:0] = clamp; write_reg(ppid_pkg::REG_CLAMP, d);
    spare = ppid_pkg::CFG_IDX_W'($urandom_range(IDX_SPARE_FIRST, IDX_SPARE_LAST));
    write_reg(spare, $urandom());
    end_writes();
    cur_sep = int'(sep);
    settings++;
  endtask

  // ------------------------------------------------------- stimulus picks

  function automatic logic signed [SW-1:0] clip_sample(input int v);
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    if (v < SAMPLE_MIN) v = SAMPLE_MIN;
    return SW'(v);
  endfunction

  // measures cluster around the separation limit so both branches get hit
  function automatic logic signed [SW-1:0] pick_measure(input int sep);
    int v;
    logic signed [SW-1:0] r;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = int'($urandom_range(0, 2 * sep + 6)) - sep - 3;
      4:          v = ($urandom_range(0, 1) ? sep : -sep) + int'($urandom_range(0, 2)) - 1;
      5:          v = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
      6:          v = 0;
      default: begin
        r = SW'($urandom());
        v = int'(r);
      end
    endcase
    return clip_sample(v);
  endfunction

  // mostly measure plus a steady bias per burst, so the integral builds up
  function automatic logic signed [SW-1:0] pick_target(input logic signed [SW-1:0] m,
                                                      input int bias);
    int v;
    logic signed [SW-1:0] r;
    case ($urandom_range(0, 5))
      0: begin
        r = SW'($urandom());
        v = int'(r);
      end
      1:       v = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
      default: v = int'(m) + bias + int'($urandom_range(0, 8)) - 4;
    endcase
    return clip_sample(v);
  endfunction

  function automatic int pick_bias();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return int'($urandom_range(0, 600)) - 300;
      2:       return int'($urandom_range(0, 40000)) - 20000;
      default: return int'($urandom_range(0, 60)) - 30;
    endcase
  endfunction

  function automatic logic [ppid_pkg::GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 6))
      0:       return 16'h8000;   // most negative
      1:       return 16'h7fff;   // most positive
      2:       return '0;
      3, 4:    return ppid_pkg::GAIN_W'(int'($urandom_range(0, 1023)) - 512);
      default: return ppid_pkg::GAIN_W'($urandom());
    endcase
  endfunction

  function automatic logic [ppid_pkg::SEP_W-1:0] pick_sep();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return ppid_pkg::SEP_W'($urandom_range(0, 100));
      3:       return ppid_pkg::SEP_W'($urandom_range(1000, 20000));
      default: return ppid_pkg::SEP_W'($urandom());
    endcase
  endfunction

  function automatic logic [ppid_pkg::CLAMP_W-1:0] pick_clamp();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return ppid_pkg::CLAMP_W'($urandom_range(0, 200));
      3:       return ppid_pkg::CLAMP_RESET;
      default: return ppid_pkg::CLAMP_W'($urandom());
    endcase
  endfunction

  // ------------------------------------------------------------- main flow

  initial begin
    int p;
    int n;
    int burst_left;
    int bias;
    logic signed [SW-1:0] t;
    logic signed [SW-1:0] m;
    logic [ppid_pkg::CFG_DATA_W-1:0] d;

    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.target  <= '0;
    in_ch.measure <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.idx    <= ppid_pkg::REG_KP;
    cfg_ch.data   <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // gains only, separation limit and clamp keep their reset values
    d = $urandom(); d[ppid_pkg::GAIN_W-1:0] = 16'h0100; write_reg(ppid_pkg::REG_KP, d); // 1.0
    d = $urandom(); d[ppid_pkg::GAIN_W-1:0] = 16'h0080; write_reg(ppid_pkg::REG_KI, d); // 0.5
    d = $urandom(); d[ppid_pkg::GAIN_W-1:0] = 16'hff80; write_reg(ppid_pkg::REG_KD, d); // -0.5
    end_writes();
    settings++;
    send_item(0, 0);
    send_item(HI_SAMPLE, 0);              // integral runs into the reset clamp
    send_item(HI_SAMPLE, 0);
    send_item(HI_SAMPLE, 0);
    send_item(LO_SAMPLE, HI_SAMPLE);      // measure right on the reset limit
    send_item(0, LO_SAMPLE);              // one past the limit, integration stops
    send_item(100, HI_SAMPLE);
    send_item(LO_SAMPLE, 0);
    send_item(LO_SAMPLE, 0);
    drain();

    // largest gains, limit and measure equal on both signs, clamp both ways
    set_config(16'h7fff, 16'h7fff, 16'h7fff, 1000, 300);
    send_item(HI_SAMPLE, LO_SAMPLE);      // largest error
    send_item(LO_SAMPLE, HI_SAMPLE);
    send_item(5000, 1000);
    send_item(-5000, -1000);
    send_item(0, 1001);
    send_item(0, -1001);
    send_item(HI_SAMPLE, 0);
    send_item(HI_SAMPLE, 0);
    send_item(LO_SAMPLE, 0);
    send_item(LO_SAMPLE, 0);
    send_item(LO_SAMPLE, 0);
    drain();

    // most negative gains, zero limit, zero clamp
    set_config(16'h8000, 16'h8000, 16'h8000, 0, 0);
    send_item(5, 0);                      // only a zero measure integrates
    send_item(5, 1);
    send_item(5, -1);
    send_item(HI_SAMPLE, 0);              // clamp of zero pins the integral
    send_item(LO_SAMPLE, 0);
    drain();

    // random phases, each under its own register setting
    for (p = 0; p < PHASES; p++) begin
      if (p == 0)
        set_config(pick_gain(), pick_gain(), pick_gain(), '1, '1);
      else
        set_config(pick_gain(), pick_gain(), pick_gain(), pick_sep(), pick_clamp());
      burst_left = 0;
      bias       = pick_bias();
      if (p == 2) begin
        // receiver holds off while the sender keeps offering back to back
        hold_asked++;
        burst_left = 60;
      end
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 16);
          bias       = pick_bias();
          if ($urandom_range(0, 24) == 0)
            drain();
          else
            pause_input($urandom_range(0, 6));
        end
        m = pick_measure(cur_sep);
        t = pick_target(m, bias);
        send_item(t, m);
        burst_left--;
      end
      drain();
    end

    repeat (10) @(posedge clk);
    $display("covered %0d items under %0d register settings, %0d results checked",
             sb.samples, settings, sb.results);
    $display("%0d items with integration on, %0d clamp hits, %0d unused-index writes,",
             sb.integ_steps, sb.clamp_hits, sb.spare_writes);
    $display("%0d long receiver hold-offs", hold_served);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
